// ===== sv/axis_angle_to_quaternion_unit_macros.svh =====
// Assertion macros for the axis-angle to quaternion unit.
// Expects clk and arst_n in the scope that uses them; no other dependencies.
`ifndef AXIS_ANGLE_TO_QUATERNION_UNIT_MACROS_SVH
`define AXIS_ANGLE_TO_QUATERNION_UNIT_MACROS_SVH

// Implication checked on every clock while out of reset
`define AAQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be seen while out of reset
`define AAQ_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== sv/aaq_pkg.sv =====
// Shared constants, coefficient tables and datapath types for the
// axis-angle to quaternion unit. No dependencies.
package aaq_pkg;

	// Fixed-point formats
	localparam int ANGLE_FRAC_BITS = 24;
	localparam int COMP_FRAC_BITS  = 30;
	localparam int AXW             = 32;

	// Half angle in Q.48: angle shifted up by this much
	localparam int ANG_SHIFT = 47 - ANGLE_FRAC_BITS;
	localparam int M_W       = AXW + ANG_SHIFT;
	localparam int V_W       = (M_W > 52) ? M_W : 52;
	// Quotient bits of the range reduction, one reduction cell each
	localparam int Q_BITS    = (ANGLE_FRAC_BITS < 27) ? 28 - ANGLE_FRAC_BITS : 1;

	localparam logic [63:0] PI_Q48      = 64'h0003_243F_6A88_85A3;
	localparam logic [63:0] TWO_PI_Q48  = PI_Q48 << 1;
	localparam logic [63:0] HALF_PI_Q48 = PI_Q48 >> 1;

	// Datapath widths
	localparam int Y_W    = 53;
	localparam int Y30_W  = 32;
	localparam int Y2_W   = 33;
	localparam int ACC_W  = 35;
	localparam int PROD_W = ACC_W + Y2_W;
	localparam int S30_W  = 33;
	localparam int SAT_W  = 68;

	// Bound on the folded angle in Q.30
	localparam logic signed [Y30_W-1:0] Y30_MAX = Y30_W'(HALF_PI_Q48 >> 18) + 1;

	// Horner cells and polynomial coefficients (Q.32, highest order first)
	localparam int HRN_N = 5;
	localparam logic signed [ACC_W-1:0] SIN_COEF [0:HRN_N] = '{
		-35'sd103, 35'sd11822, -35'sd852159,
		35'sd35791384, -35'sd715827897, 35'sd4294967296
	};
	localparam logic signed [ACC_W-1:0] COS_COEF [0:HRN_N] = '{
		-35'sd1119, 35'sd106346, -35'sd5965013,
		35'sd178956848, -35'sd2147483648, 35'sd4294967296
	};

	// Input register, reduction row, five pre-Horner stages,
	// two stages per Horner cell, four output stages
	localparam int LATENCY = 1 + Q_BITS + 5 + 2 * HRN_N + 4;

	typedef struct packed {
		logic signed [AXW-1:0] x;
		logic signed [AXW-1:0] y;
		logic signed [AXW-1:0] z;
	} axis_t;

	// Payload moving through the reduction row
	typedef struct packed {
		logic [V_W-1:0] rem;
		logic           neg;
		axis_t          axis;
	} red_t;

	// Payload moving through the Horner row
	typedef struct packed {
		logic signed [ACC_W-1:0] s_acc;
		logic signed [ACC_W-1:0] c_acc;
		logic signed [Y2_W-1:0]  y2;
		logic signed [Y30_W-1:0] y30;
		logic                    flip;
		axis_t                   axis;
	} hrn_t;

endpackage

// ===== sv/aaq_red_cell.sv =====
// One restoring step of the angle range reduction: subtracts its
// multiple of 2*pi when it fits. Depends on aaq_pkg.
module aaq_red_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       src_valid,
	input  aaq_pkg::red_t              src,
	input  logic [aaq_pkg::V_W-1:0]    divisor,
	output logic                       dst_valid,
	output aaq_pkg::red_t              dst
);

	logic [aaq_pkg::V_W:0] diff;
	logic                  valid_q;
	aaq_pkg::red_t         data_q;

	// Trial subtract; borrow out means the multiple does not fit
	assign diff = {1'b0, src.rem} - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q.rem  <= diff[aaq_pkg::V_W] ? src.rem : diff[aaq_pkg::V_W-1:0];
		data_q.neg  <= src.neg;
		data_q.axis <= src.axis;
	end

	assign dst_valid = valid_q;
	assign dst       = data_q;

endmodule

// ===== sv/aaq_hrn_cell.sv =====
// One Horner step for both polynomials: acc = round(acc * y^2 >> 30) + coef.
// Multiply stage then round-and-add stage. Depends on aaq_pkg.
module aaq_hrn_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                src_valid,
	input  aaq_pkg::hrn_t                       src,
	input  logic signed [aaq_pkg::ACC_W-1:0]    sin_coef,
	input  logic signed [aaq_pkg::ACC_W-1:0]    cos_coef,
	output logic                                dst_valid,
	output aaq_pkg::hrn_t                       dst
);

	localparam logic signed [aaq_pkg::PROD_W:0] RND30 = (aaq_pkg::PROD_W+1)'(1) <<< 29;

	logic                               valid_s1;
	logic                               valid_s2;
	logic signed [aaq_pkg::PROD_W-1:0]  s_prod_s1;
	logic signed [aaq_pkg::PROD_W-1:0]  c_prod_s1;
	aaq_pkg::hrn_t                      side_s1;
	aaq_pkg::hrn_t                      data_s2;
	logic signed [aaq_pkg::PROD_W:0]    s_rnd;
	logic signed [aaq_pkg::PROD_W:0]    c_rnd;
	logic signed [aaq_pkg::PROD_W:0]    s_sh;
	logic signed [aaq_pkg::PROD_W:0]    c_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: products with the squared angle
	always_ff @(posedge clk) begin
		s_prod_s1 <= $signed(src.s_acc) * $signed(src.y2);
		c_prod_s1 <= $signed(src.c_acc) * $signed(src.y2);
		side_s1   <= src;
	end

	// Round to nearest, ties up, back to Q.32
	always_comb begin
		s_rnd = {s_prod_s1[aaq_pkg::PROD_W-1], s_prod_s1} + RND30;
		c_rnd = {c_prod_s1[aaq_pkg::PROD_W-1], c_prod_s1} + RND30;
		s_sh  = s_rnd >>> 30;
		c_sh  = c_rnd >>> 30;
	end

	// Stage 2: add the next coefficient
	always_ff @(posedge clk) begin
		data_s2.y2    <= side_s1.y2;
		data_s2.y30   <= side_s1.y30;
		data_s2.flip  <= side_s1.flip;
		data_s2.axis  <= side_s1.axis;
		data_s2.s_acc <= $signed(s_sh[aaq_pkg::ACC_W-1:0]) + sin_coef;
		data_s2.c_acc <= $signed(c_sh[aaq_pkg::ACC_W-1:0]) + cos_coef;
	end

	assign dst_valid = valid_s2;
	assign dst       = data_s2;

endmodule

// ===== sv/axis_angle_to_quaternion_unit.sv =====
// Top level of the axis-angle to quaternion unit: input register, range
// reduction row, fold, Horner row and output scaling. Depends on aaq_pkg,
// aaq_red_cell, aaq_hrn_cell and axis_angle_to_quaternion_unit_macros.svh.
//
//  channel | dir | handshake              | fields
//  --------+-----+------------------------+--------------------------------
//  request | in  | start high, busy low   | angle, axis_x, axis_y, axis_z
//  result  | out | done strobe, one cycle | quat_x, quat_y, quat_z, quat_w
//
// One transfer is taken every cycle; each result passes one input stage, one stage
// per reduction cell, five fold/square stages, two per Horner cell, four output.
// busy is always low: the pipeline never stalls and results cannot be held.
// Reset clears only the valid flags; payload registers are not reset.

`include "axis_angle_to_quaternion_unit_macros.svh"

module axis_angle_to_quaternion_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   angle,
	input  logic signed [31:0]   axis_x,
	input  logic signed [31:0]   axis_y,
	input  logic signed [31:0]   axis_z,
	output logic                 done,
	output logic signed [31:0]   quat_x,
	output logic signed [31:0]   quat_y,
	output logic signed [31:0]   quat_z,
	output logic signed [31:0]   quat_w
);

	localparam int Y_W    = aaq_pkg::Y_W;
	localparam int V_W    = aaq_pkg::V_W;
	localparam int AXW    = aaq_pkg::AXW;
	localparam int ACC_W  = aaq_pkg::ACC_W;
	localparam int S30_W  = aaq_pkg::S30_W;
	localparam int SAT_W  = aaq_pkg::SAT_W;
	localparam int QB     = aaq_pkg::Q_BITS;
	localparam int HN     = aaq_pkg::HRN_N;
	localparam int P7_W   = ACC_W + aaq_pkg::Y30_W;
	localparam int PX_W   = S30_W + AXW;
	localparam int COMP   = aaq_pkg::COMP_FRAC_BITS;
	localparam int W_UP   = (COMP >= 30) ? COMP - 30 : 0;
	localparam int W_DN   = (COMP < 30) ? 30 - COMP : 0;

	localparam logic [V_W-1:0]          PI_V    = V_W'(aaq_pkg::PI_Q48);
	localparam logic signed [Y_W-1:0]   PI_Y    = Y_W'(aaq_pkg::PI_Q48);
	localparam logic signed [Y_W-1:0]   HALF_Y  = Y_W'(aaq_pkg::HALF_PI_Q48);
	localparam logic signed [Y_W:0]     RND18   = (Y_W+1)'(1) <<< 17;
	localparam logic signed [64:0]      RND29   = 65'sd1 <<< 29;
	localparam logic signed [P7_W:0]    RND31   = (P7_W+1)'(1) <<< 31;
	localparam logic signed [PX_W:0]    RND29X  = (PX_W+1)'(1) <<< 29;
	localparam logic signed [SAT_W-1:0] SAT_LIM = SAT_W'(1) <<< COMP;
	localparam logic signed [SAT_W-1:0] RND_W   =
		(W_DN == 0) ? SAT_W'(0) : (SAT_W'(1) <<< ((W_DN == 0) ? 0 : W_DN - 1));

	// Clamp to plus or minus one and keep the low field bits
	function automatic logic [AXW-1:0] sat_one(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] r;
		if (v > SAT_LIM) begin
			r = SAT_LIM;
		end else if (v < -SAT_LIM) begin
			r = -SAT_LIM;
		end else begin
			r = v;
		end
		return r[AXW-1:0];
	endfunction

	// Valid flags
	logic valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s7, valid_s8, valid_s9, valid_s10;

	// Row interconnect
	logic          red_valid [0:QB];
	aaq_pkg::red_t red_data  [0:QB];
	logic          hrn_valid [0:HN];
	aaq_pkg::hrn_t hrn_data  [0:HN];

	// Payload registers
	logic signed [Y_W-1:0]    y_s2, yf_s3;
	logic                     flip_s3, flip_s4, flip_s5;
	logic signed [31:0]       y30_s4, y30_s5;
	logic signed [63:0]       sq_s5;
	aaq_pkg::axis_t           axis_s2, axis_s3, axis_s4, axis_s5, axis_s7, axis_s8;
	logic signed [P7_W-1:0]   s_prod_s7;
	logic signed [S30_W-1:0]  c30_s7, s30_s8;
	logic [AXW-1:0]           w_s8, w_s9, qw_s10;
	logic signed [PX_W-1:0]   px_s9, py_s9, pz_s9;
	logic [AXW-1:0]           qx_s10, qy_s10, qz_s10;

	// Combinational helpers
	logic [31:0]              ang_mag;
	logic [aaq_pkg::M_W-1:0]  m_mag;
	logic signed [Y_W-1:0]    remy;
	logic signed [Y_W:0]      y_rnd;
	logic signed [Y_W:0]      y_sh;
	logic signed [64:0]       sq_rnd;
	logic signed [64:0]       sq_sh;
	logic signed [ACC_W:0]    c_rnd;
	logic signed [ACC_W:0]    c_sh;
	logic signed [S30_W-1:0]  c30_n;
	logic signed [P7_W:0]     s_rnd;
	logic signed [P7_W:0]     s_sh;
	logic signed [SAT_W-1:0]  c_ext;
	logic signed [SAT_W-1:0]  w_val;
	logic signed [PX_W:0]     rx, ry, rz;
	logic signed [SAT_W-1:0]  ex, ey, ez;

	assign busy = 1'b0;

	// Input stage: |half angle| in Q.48 plus pi, so that the quotient floors
	assign ang_mag = angle[31] ? 32'(-angle) : angle;
	assign m_mag   = {ang_mag, {aaq_pkg::ANG_SHIFT{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_valid[0] <= 1'b0;
		end else begin
			red_valid[0] <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		red_data[0].rem    <= V_W'(m_mag) + PI_V;
		red_data[0].neg    <= angle[31];
		red_data[0].axis.x <= axis_x;
		red_data[0].axis.y <= axis_y;
		red_data[0].axis.z <= axis_z;
	end

	// Reduction row, largest multiple of 2*pi first
	for (genvar j = 0; j < QB; j++) begin : g_red
		localparam logic [V_W-1:0] DIV = V_W'(aaq_pkg::TWO_PI_Q48 << (QB - 1 - j));
		aaq_red_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.src_valid (red_valid[j]),
			.src       (red_data[j]),
			.divisor   (DIV),
			.dst_valid (red_valid[j+1]),
			.dst       (red_data[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			valid_s5     <= 1'b0;
			hrn_valid[0] <= 1'b0;
			valid_s7     <= 1'b0;
			valid_s8     <= 1'b0;
			valid_s9     <= 1'b0;
			valid_s10    <= 1'b0;
		end else begin
			valid_s2     <= red_valid[QB];
			valid_s3     <= valid_s2;
			valid_s4     <= valid_s3;
			valid_s5     <= valid_s4;
			hrn_valid[0] <= valid_s5;
			valid_s7     <= hrn_valid[HN];
			valid_s8     <= valid_s7;
			valid_s9     <= valid_s8;
			valid_s10    <= valid_s9;
		end
	end

	// Remainder in [0, 2pi) holds h + pi; remove pi and restore the sign
	assign remy = $signed({1'b0, red_data[QB].rem[Y_W-2:0]});

	// Rounding of the folded angle to Q.30 and of the square to Q.30
	always_comb begin
		y_rnd  = {yf_s3[Y_W-1], yf_s3} + RND18;
		y_sh   = y_rnd >>> 18;
		sq_rnd = {sq_s5[63], sq_s5} + RND29;
		sq_sh  = sq_rnd >>> 30;
	end

	always_ff @(posedge clk) begin
		// signed reduced angle
		y_s2    <= red_data[QB].neg ? PI_Y - remy : remy - PI_Y;
		axis_s2 <= red_data[QB].axis;
		// fold into [-pi/2, pi/2]
		if (y_s2 > HALF_Y) begin
			yf_s3   <= PI_Y - y_s2;
			flip_s3 <= 1'b1;
		end else if (y_s2 < -HALF_Y) begin
			yf_s3   <= -PI_Y - y_s2;
			flip_s3 <= 1'b1;
		end else begin
			yf_s3   <= y_s2;
			flip_s3 <= 1'b0;
		end
		axis_s3 <= axis_s2;
		// Q.30 angle
		y30_s4  <= y_sh[31:0];
		flip_s4 <= flip_s3;
		axis_s4 <= axis_s3;
		// square
		sq_s5   <= y30_s4 * y30_s4;
		y30_s5  <= y30_s4;
		flip_s5 <= flip_s4;
		axis_s5 <= axis_s4;
		// Horner row entry
		hrn_data[0].s_acc <= aaq_pkg::SIN_COEF[0];
		hrn_data[0].c_acc <= aaq_pkg::COS_COEF[0];
		hrn_data[0].y2    <= $signed(sq_sh[aaq_pkg::Y2_W-1:0]);
		hrn_data[0].y30   <= y30_s5;
		hrn_data[0].flip  <= flip_s5;
		hrn_data[0].axis  <= axis_s5;
	end

	// Horner row
	for (genvar i = 0; i < HN; i++) begin : g_hrn
		aaq_hrn_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.src_valid (hrn_valid[i]),
			.src       (hrn_data[i]),
			.sin_coef  (aaq_pkg::SIN_COEF[i+1]),
			.cos_coef  (aaq_pkg::COS_COEF[i+1]),
			.dst_valid (hrn_valid[i+1]),
			.dst       (hrn_data[i+1])
		);
	end

	// Cosine to Q.30 with fold sign; sine product rounding; w scaling
	always_comb begin
		c_rnd = {hrn_data[HN].c_acc[ACC_W-1], hrn_data[HN].c_acc} + (ACC_W+1)'(2);
		c_sh  = c_rnd >>> 2;
		c30_n = hrn_data[HN].flip ? -$signed(c_sh[S30_W-1:0]) : $signed(c_sh[S30_W-1:0]);
		s_rnd = {s_prod_s7[P7_W-1], s_prod_s7} + RND31;
		s_sh  = s_rnd >>> 32;
		c_ext = SAT_W'(c30_s7);
		w_val = (COMP >= 30) ? (c_ext <<< W_UP) : ((c_ext + RND_W) >>> W_DN);
	end

	// Axis products rounded back to the component format
	always_comb begin
		rx = {px_s9[PX_W-1], px_s9} + RND29X;
		ry = {py_s9[PX_W-1], py_s9} + RND29X;
		rz = {pz_s9[PX_W-1], pz_s9} + RND29X;
		ex = SAT_W'(rx >>> 30);
		ey = SAT_W'(ry >>> 30);
		ez = SAT_W'(rz >>> 30);
	end

	always_ff @(posedge clk) begin
		// sine times angle, cosine finish
		s_prod_s7 <= $signed(hrn_data[HN].s_acc) * $signed(hrn_data[HN].y30);
		c30_s7    <= c30_n;
		axis_s7   <= hrn_data[HN].axis;
		// sine in Q.30, saturated w
		s30_s8    <= $signed(s_sh[S30_W-1:0]);
		w_s8      <= sat_one(w_val);
		axis_s8   <= axis_s7;
		// sine times axis
		px_s9     <= s30_s8 * axis_s8.x;
		py_s9     <= s30_s8 * axis_s8.y;
		pz_s9     <= s30_s8 * axis_s8.z;
		w_s9      <= w_s8;
		// output register
		qx_s10    <= sat_one(ex);
		qy_s10    <= sat_one(ey);
		qz_s10    <= sat_one(ez);
		qw_s10    <= w_s9;
	end

	assign done   = valid_s10;
	assign quat_x = $signed(qx_s10);
	assign quat_y = $signed(qy_s10);
	assign quat_z = $signed(qz_s10);
	assign quat_w = $signed(qw_s10);

	// Checks
	`AAQ_ASSERT_IMP(a_done_latency, done, $past(start, aaq_pkg::LATENCY), "result strobe without a transfer at the pipeline latency")
	`AAQ_ASSERT_NEVER(a_rem_range, red_valid[QB] && (red_data[QB].rem >= V_W'(aaq_pkg::TWO_PI_Q48)), "reduction remainder not below 2*pi")
	`AAQ_ASSERT_IMP(a_fold_range, valid_s4, (y30_s4 <= aaq_pkg::Y30_MAX) && (y30_s4 >= -aaq_pkg::Y30_MAX), "folded angle outside [-pi/2, pi/2]")

endmodule

// ===== tb/aaq_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the axis-angle to quaternion unit: predicts each quaternion
// from the accepted request and compares it with the next done strobe.
// Depends on aaq_pkg for the fixed-point formats.
module aaq_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] angle,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	input  logic               done,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	input  logic signed [31:0] quat_w,
	output int                 mismatches,
	output int                 accepted,
	output int                 results
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
	} quat_t;

	// pi in Q.48, rounded to nearest; pi/2 is its floor half
	localparam longint PI_Q48      = 64'sh3_243F_6A88_85A3;
	localparam longint TWO_PI_Q48  = 2 * PI_Q48;
	localparam longint HALF_PI_Q48 = PI_Q48 >>> 1;

	// Minimax coefficients in Q.32, highest order first
	localparam longint SIN_C [6] = '{
		-64'sd103, 64'sd11822, -64'sd852159,
		64'sd35791384, -64'sd715827897, 64'sd4294967296
	};
	localparam longint COS_C [6] = '{
		-64'sd1119, 64'sd106346, -64'sd5965013,
		64'sd178956848, -64'sd2147483648, 64'sd4294967296
	};

	quat_t quat_expected [$];
	quat_t head;
	int    bad;

	// Round to nearest, ties toward plus infinity
	function automatic longint rnd_shift(longint v, int s);
		if (s == 0)
			return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [31:0] clip_unit(longint v);
		longint lim;
		lim = 64'sd1 <<< aaq_pkg::COMP_FRAC_BITS;
		if (v > lim)
			v = lim;
		else if (v < -lim)
			v = -lim;
		return v[31:0];
	endfunction

	// Half angle, range reduction, fold, polynomials, axis scaling
	function automatic quat_t quat_from_axis_angle(logic signed [31:0] ang,
			logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az);
		longint half, mag, quot, rem, y, y30, y2, s_acc, c_acc, s30, c30, wv;
		longint comp [3];
		logic   fold;
		quat_t  q;
		half = longint'(ang) <<< (47 - aaq_pkg::ANGLE_FRAC_BITS);
		mag  = (half < 0) ? -half : half;
		quot = (2 * mag + TWO_PI_Q48) / (2 * TWO_PI_Q48);
		rem  = mag - quot * TWO_PI_Q48;
		y    = (half < 0) ? -rem : rem;
		fold = 1'b0;
		if (y > HALF_PI_Q48) begin
			y    = PI_Q48 - y;
			fold = 1'b1;
		end else if (y < -HALF_PI_Q48) begin
			y    = -PI_Q48 - y;
			fold = 1'b1;
		end
		y30   = rnd_shift(y, 18);
		y2    = rnd_shift(y30 * y30, 30);
		s_acc = SIN_C[0];
		c_acc = COS_C[0];
		for (int i = 1; i < 6; i++) begin
			s_acc = rnd_shift(s_acc * y2, 30) + SIN_C[i];
			c_acc = rnd_shift(c_acc * y2, 30) + COS_C[i];
		end
		s30 = rnd_shift(s_acc * y30, 32);
		c30 = rnd_shift(c_acc, 2);
		if (fold)
			c30 = -c30;
		comp[0] = ax;
		comp[1] = ay;
		comp[2] = az;
		for (int k = 0; k < 3; k++)
			comp[k] = clip_unit(rnd_shift(s30 * comp[k], 30));
		if (aaq_pkg::COMP_FRAC_BITS >= 30)
			wv = c30 <<< (aaq_pkg::COMP_FRAC_BITS - 30);
		else
			wv = rnd_shift(c30, 30 - aaq_pkg::COMP_FRAC_BITS);
		q.x = comp[0][31:0];
		q.y = comp[1][31:0];
		q.z = comp[2][31:0];
		q.w = clip_unit(wv);
		return q;
	endfunction

	function automatic int field_bad(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got === want)
			return 0;
		$display("%0t: %s expected %0d (%08h), actual %0d (%08h)",
			$time, name, want, want, got, got);
		return 1;
	endfunction

	// Record each request transfer, check each result transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			mismatches <= 0;
			accepted   <= 0;
			results    <= 0;
		end else begin
			bad = 0;
			if (start && !busy) begin
				quat_expected.push_back(quat_from_axis_angle(angle, axis_x, axis_y, axis_z));
				accepted <= accepted + 1;
			end
			if (done) begin
				results <= results + 1;
				if (quat_expected.size() == 0) begin
					$display("%0t: result with nothing expected, actual %08h %08h %08h %08h",
						$time, quat_x, quat_y, quat_z, quat_w);
					bad = 1;
				end else begin
					head = quat_expected.pop_front();
					bad += field_bad("quat_x", head.x, quat_x);
					bad += field_bad("quat_y", head.y, quat_y);
					bad += field_bad("quat_z", head.z, quat_z);
					bad += field_bad("quat_w", head.w, quat_w);
				end
			end
			mismatches <= mismatches + bad;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the axis-angle to quaternion unit: clock, reset, request
// stimulus and verdict. Depends on aaq_pkg, the unit and aaq_checker.
module tb_top;

	localparam int N_RANDOM    = 1650;
	localparam int QUIET_TAIL  = 200;
	localparam int CYCLE_LIMIT = 400_000;
	// Angles in Q8.24 near pi/2, pi and 2*pi
	localparam int HALF_PI_Q24 = 26353589;
	localparam int PI_Q24      = 52707179;
	localparam int TWO_PI_Q24  = 105414358;
	localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
	localparam logic [31:0] NEG_ONE_Q30 = 32'hC000_0000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] angle;
	logic signed [31:0] axis_x;
	logic signed [31:0] axis_y;
	logic signed [31:0] axis_z;
	logic               done;
	logic signed [31:0] quat_x;
	logic signed [31:0] quat_y;
	logic signed [31:0] quat_z;
	logic signed [31:0] quat_w;

	int mismatches;
	int accepted;
	int results;
	int cycles   = 0;
	int n_bursts = 0;

	axis_angle_to_quaternion_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.angle  (angle),
		.axis_x (axis_x),
		.axis_y (axis_y),
		.axis_z (axis_z),
		.done   (done),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.quat_w (quat_w)
	);

	aaq_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.angle      (angle),
		.axis_x     (axis_x),
		.axis_y     (axis_y),
		.axis_z     (axis_z),
		.done       (done),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.quat_w     (quat_w),
		.mismatches (mismatches),
		.accepted   (accepted),
		.results    (results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("axis_angle_to_quaternion_unit: mismatch");
			$finish;
		end
	end

	// Mode 0: anywhere in [-1, 1]; mode 1: one of -1, 0, +1
	function automatic logic [31:0] rand_comp(int mode);
		logic [31:0] r;
		if (mode == 0) begin
			r = $urandom_range(32'h8000_0000, 0);
			return r - ONE_Q30;
		end
		case ($urandom_range(2, 0))
			0:       return NEG_ONE_Q30;
			1:       return 32'h0;
			default: return ONE_Q30;
		endcase
	endfunction

	// Full range, a few turns either way, or close to a multiple of pi
	function automatic logic [31:0] rand_angle();
		int k;
		case ($urandom_range(3, 0))
			0: return $urandom;
			1: return int'($urandom_range(32'd843314864, 0)) - 421657432;
			default: begin
				k = int'($urandom_range(80, 0)) - 40;
				return k * PI_Q24 + int'($urandom_range(64, 0)) - 32;
			end
		endcase
	endfunction

	task automatic send_request(logic [31:0] a, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		@(negedge clk);
		start  = 1'b1;
		angle  = a;
		axis_x = x;
		axis_y = y;
		axis_z = z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Sender idle with junk on the data lines
	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			start  = 1'b0;
			angle  = rand_angle();
			axis_x = $urandom;
			axis_y = $urandom;
			axis_z = $urandom;
		end
	endtask

	initial begin : stimulus
		logic [31:0] dir_angle [18];
		logic [31:0] ax, ay, az;
		int          mode;
		int          n_directed;
		dir_angle = '{
			32'd0, 32'd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
			HALF_PI_Q24, -HALF_PI_Q24, PI_Q24 - 1, PI_Q24, PI_Q24 + 1, -PI_Q24,
			TWO_PI_Q24 - 1, TWO_PI_Q24, TWO_PI_Q24 + 1, -TWO_PI_Q24,
			3 * PI_Q24, 10 * TWO_PI_Q24, -10 * TWO_PI_Q24
		};
		n_directed = 0;
		start  = 1'b0;
		angle  = '0;
		axis_x = '0;
		axis_y = '0;
		axis_z = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: angle extremes, fold and reduction boundaries, axis corners
		for (int i = 0; i < 18; i++) begin
			case (i % 6)
				0: {ax, ay, az} = {ONE_Q30, 32'h0, 32'h0};
				1: {ax, ay, az} = {32'h0, ONE_Q30, 32'h0};
				2: {ax, ay, az} = {32'h0, 32'h0, NEG_ONE_Q30};
				3: {ax, ay, az} = {NEG_ONE_Q30, NEG_ONE_Q30, NEG_ONE_Q30};
				4: {ax, ay, az} = {ONE_Q30, ONE_Q30, ONE_Q30};
				default: {ax, ay, az} = {32'd619925131, -32'sd619925131, 32'd619925131};
			endcase
			send_request(dir_angle[i], ax, ay, az);
			n_directed++;
		end
		// Sine near one on an over-long axis: products saturate
		send_request(PI_Q24, ONE_Q30, ONE_Q30, ONE_Q30);
		send_request(-PI_Q24, NEG_ONE_Q30, ONE_Q30, NEG_ONE_Q30);
		send_request(PI_Q24 + 1, ONE_Q30, NEG_ONE_Q30, ONE_Q30);
		n_directed += 3;

		// Random requests; no idling in a middle stretch and in the tail
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				@(negedge clk);
				start = 1'b0;
				while (accepted != results)
					@(negedge clk);
			end
			if (i < N_RANDOM - QUIET_TAIL && (i < 300 || i >= 500) &&
					$urandom_range(5, 0) == 0) begin
				hold_off($urandom_range(16, 1));
				n_bursts++;
			end
			mode = $urandom_range(3, 0);
			if (mode == 3) begin
				{ax, ay, az} = '0;
				case ($urandom_range(2, 0))
					0:       ax = rand_comp(1);
					1:       ay = rand_comp(1);
					default: az = rand_comp(1);
				endcase
			end else begin
				ax = rand_comp(mode == 2);
				ay = rand_comp(mode == 2);
				az = rand_comp(mode == 2);
			end
			send_request(rand_angle(), ax, ay, az);
		end

		// Drain the pipeline
		@(negedge clk);
		start = 1'b0;
		while (accepted != results)
			@(posedge clk);
		repeat (aaq_pkg::LATENCY + 4) @(posedge clk);

		$display("Ran %0d directed and %0d random requests, %0d idle bursts on the request side,",
			n_directed, N_RANDOM, n_bursts);
		$display("and compared %0d of %0d expected quaternions field by field.",
			results, accepted);
		if (accepted != results)
			$display("%0d expected results never arrived", accepted - results);
		if (mismatches == 0 && accepted == results)
			$display("axis_angle_to_quaternion_unit: match");
		else
			$display("axis_angle_to_quaternion_unit: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/aaq_pkg.sv
sv/aaq_red_cell.sv
sv/aaq_hrn_cell.sv
sv/axis_angle_to_quaternion_unit.sv
tb/aaq_checker.sv
tb/tb_top.sv
